// ===== hw/rtl/slst_pkg.sv =====
// Shared types and codes for the sorted list store.
`timescale 1ns / 1ps
`default_nettype none
package slst_pkg;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_MERGE  = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_NOPOS = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELEM_WAIT,
		ST_DEL_STEP,
		ST_DEL_WR,
		ST_INS_STEP,
		ST_INS_CMP,
		ST_MRG_NEXT,
		ST_MRG_WAIT,
		ST_CMP_STEP,
		ST_CMP_WR,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slst_ram.sv =====
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_list_store_top.sv =====
// Top level of the sorted list store: sequencer around two list RAMs.
`timescale 1ns / 1ps
`default_nettype none
// Two ascending lists of signed 32-bit values, LIST_DEPTH entries each, one
// RAM per list. One item is in work at a time and gives one result beat.
// Read and delete fetch the element at the position; delete then shifts the
// entries above it down one place each. Insert finds the landing place with a
// read-compare-write step that walks down from the tail; merge inserts each
// element of list two into list one that way, and a stopped merge then
// compacts list two. The RAMs need no clearing: only entries below the counts
// are ever read.
module sorted_list_store_top #(
	parameter int LIST_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic               list_sel,
	input  wire logic signed [31:0] value,
	input  wire logic [5:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      elem_value,
	output logic [5:0]              count_after
);

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int WW = (CW > 6) ? CW : 6;

	slst_pkg::state_t state_q, state_d;

	logic [1:0]         op_q, op_d;
	logic               sel_q, sel_d;
	logic signed [31:0] val_q, val_d;
	logic [CW-1:0]      k_q, k_d;
	logic [CW-1:0]      j_q, j_d;
	logic [CW-1:0]      cnt1_q, cnt1_d, cnt2_q, cnt2_d;
	logic [1:0]         stat_q, stat_d;
	logic [31:0]        elem_q, elem_d;
	logic               out_valid_q, out_valid_d;
	logic [1:0]         out_stat_q, out_stat_d;
	logic [31:0]        out_elem_q, out_elem_d;
	logic [5:0]         out_cnt_q, out_cnt_d;

	logic          we1, we2;
	logic [AW-1:0] waddr1, waddr2, raddr1, raddr2;
	logic [31:0]   wdata1, wdata2, rdata1, rdata2;

	slst_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_one (
		.clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata1),
		.raddr(raddr1), .rdata(rdata1)
	);

	slst_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_two (
		.clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata2),
		.raddr(raddr2), .rdata(rdata2)
	);

	logic [CW-1:0]      in_cnt, sel_cnt, k_m1;
	logic [WW-1:0]      pos_w, fin_cnt_w;
	logic [CW:0]        k_p1, k_pj;
	logic [31:0]        sel_rdata;
	logic signed [31:0] sel_rs;
	logic               do_move;

	always_comb begin
		in_cnt    = list_sel ? cnt2_q : cnt1_q;
		sel_cnt   = sel_q ? cnt2_q : cnt1_q;
		pos_w     = WW'(position);
		k_m1      = k_q - 1'b1;
		k_p1      = {1'b0, k_q} + 1'b1;
		k_pj      = {1'b0, k_q} + {1'b0, j_q};
		sel_rdata = sel_q ? rdata2 : rdata1;
		sel_rs    = $signed(sel_rdata);
		// head moves only when strictly larger; others move when not smaller
		do_move   = (k_q == CW'(1)) ? (val_q < sel_rs) : !(sel_rs < val_q);
		fin_cnt_w = WW'(sel_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slst_pkg::ST_IDLE;
			cnt1_q      <= '0;
			cnt2_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt1_q      <= cnt1_d;
			cnt2_q      <= cnt2_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q       <= op_d;
		sel_q      <= sel_d;
		val_q      <= val_d;
		k_q        <= k_d;
		j_q        <= j_d;
		stat_q     <= stat_d;
		elem_q     <= elem_d;
		out_stat_q <= out_stat_d;
		out_elem_q <= out_elem_d;
		out_cnt_q  <= out_cnt_d;
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		sel_d       = sel_q;
		val_d       = val_q;
		k_d         = k_q;
		j_d         = j_q;
		cnt1_d      = cnt1_q;
		cnt2_d      = cnt2_q;
		stat_d      = stat_q;
		elem_d      = elem_q;
		out_valid_d = out_valid_q;
		out_stat_d  = out_stat_q;
		out_elem_d  = out_elem_q;
		out_cnt_d   = out_cnt_q;
		in_ready    = 1'b0;
		we1         = 1'b0;
		we2         = 1'b0;
		waddr1      = k_q[AW-1:0];
		waddr2      = k_q[AW-1:0];
		wdata1      = 32'(val_q);
		wdata2      = 32'(val_q);
		raddr1      = k_m1[AW-1:0];
		raddr2      = k_m1[AW-1:0];

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			slst_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				raddr1   = pos_w[AW-1:0];
				raddr2   = pos_w[AW-1:0];
				if (in_valid) begin
					op_d   = func;
					sel_d  = list_sel;
					val_d  = value;
					elem_d = '0;
					stat_d = slst_pkg::STAT_OK;
					k_d    = in_cnt;
					j_d    = '0;
					unique case (func)
						slst_pkg::FUNC_INSERT: begin
							if (in_cnt == CW'(LIST_DEPTH)) begin
								stat_d  = slst_pkg::STAT_FULL;
								state_d = slst_pkg::ST_FIN;
							end else begin
								state_d = slst_pkg::ST_INS_STEP;
							end
						end
						slst_pkg::FUNC_DELETE, slst_pkg::FUNC_READ: begin
							k_d = pos_w[CW-1:0];
							if (in_cnt == '0) begin
								stat_d  = slst_pkg::STAT_EMPTY;
								state_d = slst_pkg::ST_FIN;
							end else if (pos_w >= WW'(in_cnt)) begin
								stat_d  = slst_pkg::STAT_NOPOS;
								state_d = slst_pkg::ST_FIN;
							end else begin
								state_d = slst_pkg::ST_ELEM_WAIT;
							end
						end
						slst_pkg::FUNC_MERGE: begin
							sel_d = 1'b0;
							if (cnt1_q == '0 && cnt2_q == '0) begin
								stat_d  = slst_pkg::STAT_EMPTY;
								state_d = slst_pkg::ST_FIN;
							end else begin
								state_d = slst_pkg::ST_MRG_NEXT;
							end
						end
						default: state_d = slst_pkg::ST_FIN;
					endcase
				end
			end
			slst_pkg::ST_ELEM_WAIT: begin
				elem_d = sel_rdata;
				state_d = (op_q == slst_pkg::FUNC_READ) ? slst_pkg::ST_FIN
					: slst_pkg::ST_DEL_STEP;
			end
			slst_pkg::ST_DEL_STEP: begin
				raddr1 = k_p1[AW-1:0];
				raddr2 = k_p1[AW-1:0];
				if (k_p1 < {1'b0, sel_cnt}) begin
					state_d = slst_pkg::ST_DEL_WR;
				end else begin
					if (sel_q) cnt2_d = cnt2_q - 1'b1;
					else       cnt1_d = cnt1_q - 1'b1;
					state_d = slst_pkg::ST_FIN;
				end
			end
			slst_pkg::ST_DEL_WR: begin
				we1     = !sel_q;
				we2     = sel_q;
				wdata1  = rdata1;
				wdata2  = rdata2;
				k_d     = k_p1[CW-1:0];
				state_d = slst_pkg::ST_DEL_STEP;
			end
			slst_pkg::ST_INS_STEP: begin
				if (k_q == '0) begin
					we1 = !sel_q;
					we2 = sel_q;
					if (sel_q) cnt2_d = cnt2_q + 1'b1;
					else       cnt1_d = cnt1_q + 1'b1;
					if (op_q == slst_pkg::FUNC_MERGE) begin
						j_d     = j_q + 1'b1;
						state_d = slst_pkg::ST_MRG_NEXT;
					end else begin
						state_d = slst_pkg::ST_FIN;
					end
				end else begin
					state_d = slst_pkg::ST_INS_CMP;
				end
			end
			slst_pkg::ST_INS_CMP: begin
				we1 = !sel_q;
				we2 = sel_q;
				if (do_move) begin
					wdata1  = rdata1;
					wdata2  = rdata2;
					k_d     = k_m1;
					state_d = slst_pkg::ST_INS_STEP;
				end else begin
					if (sel_q) cnt2_d = cnt2_q + 1'b1;
					else       cnt1_d = cnt1_q + 1'b1;
					if (op_q == slst_pkg::FUNC_MERGE) begin
						j_d     = j_q + 1'b1;
						state_d = slst_pkg::ST_MRG_NEXT;
					end else begin
						state_d = slst_pkg::ST_FIN;
					end
				end
			end
			slst_pkg::ST_MRG_NEXT: begin
				raddr2 = j_q[AW-1:0];
				if (j_q < cnt2_q) begin
					if (cnt1_q == CW'(LIST_DEPTH)) begin
						stat_d  = slst_pkg::STAT_FULL;
						k_d     = '0;
						state_d = (j_q == '0) ? slst_pkg::ST_FIN
							: slst_pkg::ST_CMP_STEP;
					end else begin
						state_d = slst_pkg::ST_MRG_WAIT;
					end
				end else begin
					cnt2_d  = '0;
					state_d = slst_pkg::ST_FIN;
				end
			end
			slst_pkg::ST_MRG_WAIT: begin
				val_d   = $signed(rdata2);
				k_d     = cnt1_q;
				state_d = slst_pkg::ST_INS_STEP;
			end
			// stopped merge: slide the unmoved tail of list two down by j
			slst_pkg::ST_CMP_STEP: begin
				raddr2 = k_pj[AW-1:0];
				if (k_pj < {1'b0, cnt2_q}) begin
					state_d = slst_pkg::ST_CMP_WR;
				end else begin
					cnt2_d  = cnt2_q - j_q;
					state_d = slst_pkg::ST_FIN;
				end
			end
			slst_pkg::ST_CMP_WR: begin
				we2     = 1'b1;
				wdata2  = rdata2;
				k_d     = k_p1[CW-1:0];
				state_d = slst_pkg::ST_CMP_STEP;
			end
			slst_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d = 1'b1;
					out_stat_d  = stat_q;
					out_elem_d  = elem_q;
					out_cnt_d   = fin_cnt_w[5:0];
					state_d     = slst_pkg::ST_IDLE;
				end
			end
			default: state_d = slst_pkg::ST_IDLE;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = out_stat_q;
	assign elem_value  = $signed(out_elem_q);
	assign count_after = out_cnt_q;

`ifndef NO_ASSERTIONS
	a_cnt1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt1_q <= CW'(LIST_DEPTH))
		else $error("list one count beyond depth");
	a_cnt2_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt2_q <= CW'(LIST_DEPTH))
		else $error("list two count beyond depth");
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(we1 && we2))
		else $error("both list RAMs written at once");
	a_merge_target: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == slst_pkg::FUNC_MERGE && state_q == slst_pkg::ST_INS_CMP) |-> !we2)
		else $error("merge insert wrote list two");
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != slst_pkg::ST_IDLE)
		else $error("accepted beat did not start work");
`endif

endmodule
`default_nettype wire
